@@ rtl/alr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants of the anti-aliased line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 32;
  localparam int SCREEN_HEIGHT_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int PERIOD_W   = 8;
  localparam int PIX_W      = 5;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One classified draw command: a = major axis, b = minor axis, a1 <= a2.
  typedef struct packed {
    logic                single;
    logic                xmajor;
    coord_t              a1;
    coord_t              b1;
    coord_t              a2;
    coord_t              b2;
    logic [COLOR_W-1:0]  color;
    logic [PERIOD_W-1:0] period;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage
`default_nettype wire

@@ rtl/antialiased_line_rasterizer.sv @@
`default_nettype none
// A pixel command's write passes the command queue, the walker state, the held slot
// and the output register before out_tvalid rises; a line first runs the slope
// divider for COORD_W+FRACTION_BITS quotient bits (28 at 16). A drawn step walks
// S_STEP, S_RD, S_NEAR and S_FAR, waiting while the output is stalled; a skipped or
// off-screen step advances from S_STEP alone. Reset: after rst_n the framebuffer,
// SCREEN_WIDTH*SCREEN_HEIGHT words (1024 by default), is cleared with in_tready low.
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu-style anti-aliased line and pixel drawing into an RGBA framebuffer.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer #(
  parameter int SCREEN_WIDTH  = alr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = alr_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRACTION_BITS = alr_pkg::FRACTION_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36],
  // line_color[79:48], dash_period[87:80]
  input  wire [alr_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode[0]
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // pixel_x[4:0], pixel_y[9:5], pixel_color[41:10], zero pad [47:42]
  output logic [alr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast
);

  logic                q_valid;
  alr_pkg::item_t      q_item;
  alr_pkg::back_stat_t stat;

  alr_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .stat     (stat)
  );

  alr_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .stat      (stat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

@@ rtl/alr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alr_front
// Accepts commands, sorts endpoints along the major axis, drops lines whose
// endpoints all lie outside the screen in x and in y, and queues the rest for the walker.
// ----------------------------------------------------------------------------
module alr_front #(
  parameter int SCREEN_WIDTH  = alr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = alr_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [alr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire                            in_tuser,
  output logic                           q_valid,
  output alr_pkg::item_t                 q_item,
  input  alr_pkg::back_stat_t            stat
);

  localparam logic signed [12:0] W_S = 13'(SCREEN_WIDTH);
  localparam logic signed [12:0] H_S = 13'(SCREEN_HEIGHT);

  alr_pkg::coord_t x1, y1, x2, y2;
  logic signed [12:0] dx, dy, adx, ady;
  logic xmajor, swap, skip, accept;
  alr_pkg::item_t cls;

  alr_pkg::item_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign x1 = in_tdata[11:0];
  assign y1 = in_tdata[23:12];
  assign x2 = in_tdata[35:24];
  assign y2 = in_tdata[47:36];

  function automatic logic outside(input alr_pkg::coord_t v, input logic signed [12:0] lim);
    logic signed [12:0] w;
    w = 13'(v);
    return (w < 0) || (w >= lim);
  endfunction

  always_comb begin
    dx     = 13'(x2) - 13'(x1);
    dy     = 13'(y2) - 13'(y1);
    adx    = dx[12] ? -dx : dx;
    ady    = dy[12] ? -dy : dy;
    xmajor = adx > ady;
    swap   = xmajor ? (x1 > x2) : (y1 > y2);
    skip   = in_tuser && outside(x1, W_S) && outside(x2, W_S) &&
             outside(y1, H_S) && outside(y2, H_S);
    cls.single = !in_tuser;
    cls.xmajor = xmajor || !in_tuser;
    cls.color  = in_tdata[79:48];
    cls.period = in_tdata[87:80];
    if (!in_tuser) begin
      cls.a1 = x1; cls.b1 = y1; cls.a2 = x1; cls.b2 = y1;
    end else if (xmajor) begin
      cls.a1 = swap ? x2 : x1; cls.b1 = swap ? y2 : y1;
      cls.a2 = swap ? x1 : x2; cls.b2 = swap ? y1 : y2;
    end else begin
      cls.a1 = swap ? y2 : y1; cls.b1 = swap ? x2 : x1;
      cls.a2 = swap ? y1 : y2; cls.b2 = swap ? x1 : x2;
    end
  end

  assign in_tready = !stat.clearing && (count_r != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign q_valid   = count_r != 2'd0;
  assign q_item    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept && !skip) begin
      wr_ptr_nxt = !wr_ptr_r;
      count_nxt  = count_nxt + 2'd1;
    end
    if (stat.pop) begin
      rd_ptr_nxt = !rd_ptr_r;
      count_nxt  = count_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !skip) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

@@ rtl/alr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alr_back
// Framebuffer, slope divider and Wu step walker. Each pixel write is held
// one slot so the final write of a command can be flagged.
// ----------------------------------------------------------------------------
module alr_back #(
  parameter int SCREEN_WIDTH  = alr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = alr_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRACTION_BITS = alr_pkg::FRACTION_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_valid,
  input  alr_pkg::item_t                  q_item,
  output alr_pkg::back_stat_t             stat,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [alr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast
);

  localparam int F     = FRACTION_BITS;
  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = alr_pkg::COORD_W + F;
  localparam int CW    = $clog2(NW + 1);
  localparam int ACC_W = F + 15;
  localparam int PW    = F + 10;
  localparam logic signed [12:0] W_S = 13'(SCREEN_WIDTH);
  localparam logic signed [12:0] H_S = 13'(SCREEN_HEIGHT);
  localparam logic signed [ACC_W-1:0] W_ACC = ACC_W'(SCREEN_WIDTH) << F;
  localparam logic signed [ACC_W-1:0] H_ACC = ACC_W'(SCREEN_HEIGHT) << F;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_EP0   = 10'b0000001000,
    S_EP1   = 10'b0000010000,
    S_STEP  = 10'b0000100000,
    S_RD    = 10'b0001000000,
    S_NEAR  = 10'b0010000000,
    S_FAR   = 10'b0100000000,
    S_FLUSH = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  alr_pkg::item_t item_r, item_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic signed [12:0] a_r, a_nxt, p_r, p_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, slope_r, slope_nxt;
  logic [11:0] da_r, da_nxt, rem_r, rem_nxt;
  logic neg_r, neg_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0] dash_r, dash_nxt;
  logic [F-1:0] f_r, f_nxt;
  logic bgz_r, bgz_nxt;
  logic [31:0] bg_r, bg_nxt;
  logic signed [PW-1:0] prod_r [4];
  logic signed [PW-1:0] prod_nxt [4];
  logic held_v_r, held_v_nxt;
  logic [4:0] held_x_r, held_x_nxt, held_y_r, held_y_nxt;
  logic [31:0] held_c_r, held_c_nxt;
  logic out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  logic [4:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [31:0] out_c_r, out_c_nxt;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  logic out_free, emit_ok;
  logic signed [12:0] wr_x, wr_y, bx, by, da_s, db_s;
  logic [31:0] wr_c, near_c, far_c;
  logic wr_req, wr_done, adv, drawn;
  logic [12:0] t;
  logic [5:0] p_pos;

  function automatic logic on_scr(input logic signed [12:0] x, input logic signed [12:0] y);
    return (x > 0) && (x < W_S) && (y > 0) && (y < H_S);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic signed [12:0] x,
                                            input logic signed [12:0] y);
    return AW'(int'(y[5:0]) * SCREEN_WIDTH + int'(x[5:0]));
  endfunction

  assign out_free = !out_v_r || out_tready;
  assign emit_ok  = !held_v_r || out_free;

  // Blend both neighbors from one product per channel.
  always_comb begin
    logic signed [PW-1:0] sn, sf;
    for (int ch = 0; ch < 4; ch++) begin
      sn = $signed({2'b00, item_r.color[ch*8 +: 8], {F{1'b0}}}) + prod_r[ch];
      sf = $signed({2'b00, bg_r[ch*8 +: 8], {F{1'b0}}}) - prod_r[ch];
      near_c[ch*8 +: 8] = sn[F +: 8];
      far_c[ch*8 +: 8]  = sf[F +: 8];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    clr_nxt    = clr_r;
    a_nxt      = a_r;
    p_nxt      = p_r;
    acc_nxt    = acc_r;
    slope_nxt  = slope_r;
    da_nxt     = da_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    dash_nxt   = dash_r;
    f_nxt      = f_r;
    bgz_nxt    = bgz_r;
    bg_nxt     = bg_r;
    prod_nxt   = prod_r;
    held_v_nxt = held_v_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    held_c_nxt = held_c_r;
    out_v_nxt    = out_tready ? 1'b0 : out_v_r;
    out_last_nxt = out_last_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_c_nxt    = out_c_r;
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    wr_req    = 1'b0;
    wr_x      = '0;
    wr_y      = '0;
    wr_c      = '0;
    adv       = 1'b0;
    t         = {rem_r, quo_r[NW-1]};
    da_s      = 13'(q_item.a2) - 13'(q_item.a1);
    db_s      = 13'(q_item.b2) - 13'(q_item.b1);
    p_pos     = acc_r[F +: 6];
    bx        = item_r.xmajor ? a_r : 13'($signed({1'b0, p_pos}));
    by        = item_r.xmajor ? 13'($signed({1'b0, p_pos})) : a_r;
    mem_raddr = addr_of(bx, by);
    drawn     = ((item_r.period == 8'd0) || (dash_r != 8'd0)) && (a_r > 0) &&
                (acc_r > 0) && (acc_r < (item_r.xmajor ? H_ACC : W_ACC));

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          item_nxt = q_item;
          da_nxt   = da_s[11:0];
          neg_nxt  = db_s[12];
          quo_nxt  = {(db_s[12] ? 12'(-db_s) : db_s[11:0]), {F{1'b0}}};
          rem_nxt  = '0;
          cnt_nxt  = CW'(NW);
          state_nxt = q_item.single ? S_EP0 : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r != '0) begin
          if (t >= {1'b0, da_r}) begin
            rem_nxt = 12'(t - {1'b0, da_r});
            quo_nxt = {quo_r[NW-2:0], 1'b1};
          end else begin
            rem_nxt = t[11:0];
            quo_nxt = {quo_r[NW-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          if (da_r == 12'd0) begin
            slope_nxt = '0;
          end else if (neg_r) begin
            slope_nxt = -$signed(ACC_W'(quo_r));
          end else begin
            slope_nxt = $signed(ACC_W'(quo_r));
          end
          acc_nxt   = (ACC_W'(item_r.b1) <<< F) + slope_nxt;
          a_nxt     = 13'(item_r.a1) + 13'sd1;
          dash_nxt  = '0;
          state_nxt = S_EP0;
        end
      end
      S_EP0: begin
        wr_req = 1'b1;
        wr_x   = item_r.xmajor ? 13'(item_r.a1) : 13'(item_r.b1);
        wr_y   = item_r.xmajor ? 13'(item_r.b1) : 13'(item_r.a1);
        wr_c   = item_r.color;
      end
      S_EP1: begin
        wr_req = 1'b1;
        wr_x   = item_r.xmajor ? 13'(item_r.a2) : 13'(item_r.b2);
        wr_y   = item_r.xmajor ? 13'(item_r.b2) : 13'(item_r.a2);
        wr_c   = item_r.color;
      end
      S_STEP: begin
        if ((a_r > 13'(item_r.a2)) || (a_r >= (item_r.xmajor ? W_S : H_S))) begin
          state_nxt = S_FLUSH;
        end else if (drawn) begin
          p_nxt     = 13'($signed({1'b0, p_pos}));
          f_nxt     = acc_r[F-1:0];
          bgz_nxt   = !on_scr(bx, by);
          mem_re    = on_scr(bx, by);
          state_nxt = S_RD;
        end else begin
          adv = 1'b1;
        end
      end
      S_RD: begin
        bg_nxt = bgz_r ? 32'd0 : rdata_r;
        for (int ch = 0; ch < 4; ch++) begin
          prod_nxt[ch] = PW'($signed({1'b0, f_r}) *
                         ($signed({1'b0, bg_nxt[ch*8 +: 8]}) -
                          $signed({1'b0, item_r.color[ch*8 +: 8]})));
        end
        state_nxt = S_NEAR;
      end
      S_NEAR: begin
        wr_req = 1'b1;
        wr_x   = item_r.xmajor ? a_r : p_r;
        wr_y   = item_r.xmajor ? p_r : a_r;
        wr_c   = near_c;
      end
      S_FAR: begin
        wr_req = 1'b1;
        wr_x   = item_r.xmajor ? a_r : p_r + 13'sd1;
        wr_y   = item_r.xmajor ? p_r + 13'sd1 : a_r;
        wr_c   = far_c;
      end
      S_FLUSH: begin
        if (!held_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_last_nxt = 1'b1;
          out_x_nxt    = held_x_r;
          out_y_nxt    = held_y_r;
          out_c_nxt    = held_c_r;
          held_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // Pixel write: store, hold, and pass the previously held write on.
    wr_done = wr_req && (!on_scr(wr_x, wr_y) || emit_ok);
    if (wr_req && on_scr(wr_x, wr_y) && emit_ok) begin
      mem_we     = 1'b1;
      mem_waddr  = addr_of(wr_x, wr_y);
      mem_wdata  = wr_c;
      if (held_v_r) begin
        out_v_nxt    = 1'b1;
        out_last_nxt = 1'b0;
        out_x_nxt    = held_x_r;
        out_y_nxt    = held_y_r;
        out_c_nxt    = held_c_r;
      end
      held_v_nxt = 1'b1;
      held_x_nxt = wr_x[4:0];
      held_y_nxt = wr_y[4:0];
      held_c_nxt = wr_c;
    end
    if (wr_done) begin
      case (state_r)
        S_EP0:   state_nxt = item_r.single ? S_FLUSH : S_EP1;
        S_EP1:   state_nxt = S_STEP;
        S_NEAR:  state_nxt = S_FAR;
        S_FAR: begin
          state_nxt = S_STEP;
          adv       = 1'b1;
        end
        default: state_nxt = state_nxt;
      endcase
    end

    if (adv) begin
      a_nxt    = a_r + 13'sd1;
      acc_nxt  = acc_r + slope_r;
      dash_nxt = (dash_r + 8'd1 == item_r.period) ? 8'd0 : dash_r + 8'd1;
    end
  end

  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.pop      = (state_r == S_IDLE) && q_valid;

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_c_r, out_y_r, out_x_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    a_r        <= a_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    slope_r    <= slope_nxt;
    da_r       <= da_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    dash_r     <= dash_nxt;
    f_r        <= f_nxt;
    bgz_r      <= bgz_nxt;
    bg_r       <= bg_nxt;
    prod_r     <= prod_nxt;
    held_x_r   <= held_x_nxt;
    held_y_r   <= held_y_nxt;
    held_c_r   <= held_c_nxt;
    out_last_r <= out_last_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_c_r    <= out_c_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/alr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alr_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module alr_checker #(
  parameter int SCREEN_WIDTH  = alr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = alr_pkg::SCREEN_HEIGHT_DEF
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [alr_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                             out_tlast
);

  // Clearing pass holds off input right after reset.
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during framebuffer clear");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] != 5'd0) && (out_tdata[9:5] != 5'd0) &&
                   (int'(out_tdata[4:0]) < SCREEN_WIDTH) &&
                   (int'(out_tdata[9:5]) < SCREEN_HEIGHT))
    else $error("write outside the drawable area");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed while stalled");

endmodule

bind antialiased_line_rasterizer alr_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_alr_checker (.*);
`default_nettype wire

@@ tb/antialiased_line_rasterizer_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_tb
// Drives pixel and line commands into the rasterizer with random idle cycles
// on both streams, and compares every framebuffer write it emits with a
// behavioral copy of the framebuffer and the line walk kept in the bench.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_tb;

  localparam int SW = 32;
  localparam int SH = 32;
  localparam int FB = 16;
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_LINE  = 1'b1;

  typedef struct packed {
    logic [4:0]  px;
    logic [4:0]  py;
    logic [31:0] color;
    logic        last;
  } wr_t;

  typedef struct {
    logic        mode;
    int          x1, y1, x2, y2;
    logic [31:0] color;
    logic [7:0]  period;
    int          nexp;   // -1: predictor only
    logic [31:0] exp_color;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [alr_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tready = 1'b0;
  wire in_tready;
  wire out_tvalid;
  wire [alr_pkg::OUT_DATA_W-1:0] out_tdata;
  wire out_tlast;

  logic [31:0] fb_model [SW*SH];
  wr_t writes_due[$];
  int errors = 0;
  bit calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  antialiased_line_rasterizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  function automatic bit on_screen(int x, int y);
    return x > 0 && y > 0 && x < SW && y < SH;
  endfunction

  function automatic logic [31:0] mix(longint unsigned f, logic [31:0] c1,
                                      logic [31:0] c2);
    logic [31:0] r;
    longint unsigned v;
    r = '0;
    for (int s = 0; s < 32; s += 8) begin
      v = (f * c1[s+:8] + ((64'd1 << FB) - f) * c2[s+:8]) >> FB;
      r[s+:8] = v[7:0];
    end
    return r;
  endfunction

  task automatic plot(int x, int y, logic [31:0] c, ref int cnt);
    wr_t w;
    if (!on_screen(x, y) || cnt >= 64) return;
    fb_model[y*SW+x] = c;
    w.px = x[4:0];
    w.py = y[4:0];
    w.color = c;
    w.last = 1'b0;
    writes_due.insert(writes_due.size(), w);
    cnt++;
  endtask

  task automatic trace(int a1, int b1, int a2, int b2, bit xm, logic [31:0] c,
                       int per, ref int cnt);
    longint one, slope, acc;
    int lim_a, lim_b, p, stp;
    longint unsigned f;
    logic [31:0] bg;
    one = 64'sd1 <<< FB;
    lim_a = xm ? SW : SH;
    lim_b = xm ? SH : SW;
    slope = (a2 != a1) ? (longint'(b2 - b1) * one) / longint'(a2 - a1) : 0;
    acc = longint'(b1) * one + slope;
    stp = 0;
    if (xm) begin
      plot(a1, b1, c, cnt);
      plot(a2, b2, c, cnt);
    end else begin
      plot(b1, a1, c, cnt);
      plot(b2, a2, c, cnt);
    end
    for (int a = a1 + 1; a <= a2; a++) begin
      if ((per == 0 || stp % per != 0) && a > 0 && a < lim_a && acc > 0 &&
          acc < longint'(lim_b) * one) begin
        p = int'(acc >>> FB);
        f = acc & (one - 1);
        if (xm) bg = on_screen(a, p) ? fb_model[p*SW+a] : '0;
        else bg = on_screen(p, a) ? fb_model[a*SW+p] : '0;
        if (xm) begin
          plot(a, p, mix(f, bg, c), cnt);
          plot(a, p + 1, mix(f, c, bg), cnt);
        end else begin
          plot(p, a, mix(f, bg, c), cnt);
          plot(p + 1, a, mix(f, c, bg), cnt);
        end
      end
      stp++;
      acc += slope;
    end
  endtask

  task automatic predict_draw(cmd_t cm);
    int cnt, adx, ady;
    int base;
    cnt = 0;
    base = writes_due.size();
    if (cm.mode == MODE_PIXEL) begin
      plot(cm.x1, cm.y1, cm.color, cnt);
    end else if (!((cm.x1 < 0 || cm.x1 >= SW) && (cm.x2 < 0 || cm.x2 >= SW) &&
                   (cm.y1 < 0 || cm.y1 >= SH) && (cm.y2 < 0 || cm.y2 >= SH))) begin
      adx = cm.x2 > cm.x1 ? cm.x2 - cm.x1 : cm.x1 - cm.x2;
      ady = cm.y2 > cm.y1 ? cm.y2 - cm.y1 : cm.y1 - cm.y2;
      if (adx > ady) begin
        if (cm.x1 > cm.x2) trace(cm.x2, cm.y2, cm.x1, cm.y1, 1, cm.color, cm.period, cnt);
        else trace(cm.x1, cm.y1, cm.x2, cm.y2, 1, cm.color, cm.period, cnt);
      end else begin
        if (cm.y1 > cm.y2) trace(cm.y2, cm.x2, cm.y1, cm.x1, 0, cm.color, cm.period, cnt);
        else trace(cm.y1, cm.x1, cm.y2, cm.x2, 0, cm.color, cm.period, cnt);
      end
    end
    if (cnt > 0) writes_due[$].last = 1'b1;
    // check the hand-typed rows against the predictor's own result
    if (cm.nexp >= 0) begin
      if (cnt != cm.nexp || (cnt > 0 && writes_due[base].color != cm.exp_color)) begin
        $display("%0t: table row count exp %0d got %0d", $time, cm.nexp, cnt);
        errors++;
      end
    end
  endtask

  task automatic send(cmd_t cm);
    bit ready_seen;
    if (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 10) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cm.mode;
    in_tdata <= {cm.period, cm.color, cm.y2[11:0], cm.x2[11:0], cm.y1[11:0], cm.x1[11:0]};
    predict_draw(cm);
    // in_tready only follows registers, so its value before the edge is stable
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  function automatic int rnd_coord();
    case ($urandom_range(9))
      0: return $signed($urandom_range(4095)) - 2048;
      1: return $urandom_range(1) ? 2047 : -2048;
      2: return int'($urandom_range(50)) - 10;
      default: return $urandom_range(31);
    endcase
  endfunction

  always @(posedge clk) begin
    wr_t w, got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.px = out_tdata[4:0];
        got.py = out_tdata[9:5];
        got.color = out_tdata[41:10];
        got.last = out_tlast;
        if (writes_due.size() == 0) begin
          $display("%0t: unexpected write exp none act %h", $time, got);
          errors++;
        end else begin
          w = writes_due.pop_front();
          if (got !== w || out_tdata[47:42] !== 6'd0) begin
            $display("%0t: write mismatch exp %h act %h", $time, w, got);
            errors++;
          end
        end
      end
      out_tready <= calm || $urandom_range(99) >= 10;
    end
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    cmd_t tbl[$];
    cmd_t cm;
    int n;
    for (int i = 0; i < SW*SH; i++) fb_model[i] = '0;
    // mode, x1,y1,x2,y2, color, period, writes, first color
    tbl.insert(tbl.size(), cmd_t'{MODE_PIXEL, 1, 1, 0, 0, 32'hFFFFFFFF, 0, 1, 32'hFFFFFFFF});
    tbl.insert(tbl.size(), cmd_t'{MODE_PIXEL, 31, 31, 0, 0, 32'h00000000, 0, 1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_PIXEL, 0, 5, 0, 0, 32'h12345678, 0, 0, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_PIXEL, 5, 0, 0, 0, 32'h12345678, 0, 0, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_PIXEL, 32, 5, 0, 0, 32'h1, 0, 0, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_PIXEL, -2048, 2047, 2047, -2048, 32'h1, 255, 0,
                                  32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, -1, -1, 40, 40, 32'hAABBCCDD, 0, 0, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, -2048, -2048, 2047, 2047, 32'hA, 0, -1,
                                  32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 7, 7, 7, 7, 32'hCAFEF00D, 0, 2, 32'hCAFEF00D});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 1, 2, 30, 9, 32'h80FF4020, 0, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 30, 9, 1, 2, 32'h11223344, 3, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 3, 1, 10, 30, 32'hFF00FF00, 0, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 10, 30, 3, 1, 32'h00FF00FF, 1, 0 + 2,
                                  32'h00FF00FF});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 0, 0, 31, 31, 32'h7F7F7F7F, 2, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 31, 0, 0, 31, 32'hFEDCBA98, 255, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, -5, 4, 40, 20, 32'h55AA55AA, 0, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 5, -7, 20, 45, 32'h0F0F0F0F, 4, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 2, 5, 12, 5, 32'hFFFFFFFF, 0, -1, 32'h0});
    tbl.insert(tbl.size(), cmd_t'{MODE_LINE, 4, 4, 8, 8, 32'h01020304, 0, -1, 32'h0});
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (tbl[i]) send(tbl[i]);
    for (int i = 0; i < 360; i++) begin
      calm = (i >= 150 && i < 210);
      cm.mode = $urandom_range(3) != 0 ? MODE_LINE : MODE_PIXEL;
      cm.x1 = rnd_coord();
      cm.y1 = rnd_coord();
      cm.x2 = rnd_coord();
      cm.y2 = rnd_coord();
      cm.color = $urandom();
      n = $urandom_range(3);
      cm.period = n == 0 ? 8'd0 : (n == 1 ? 8'($urandom()) : 8'($urandom_range(5)));
      cm.nexp = -1;
      cm.exp_color = '0;
      send(cm);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    n = 0;
    while (writes_due.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && writes_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
